// File: hdl/csld_pkg.sv
// Package with the constants, codes and types shared by the CompactSize decoder files.
package csld_pkg;

  // Prefix bytes that announce a multi-byte value.
  localparam logic [7:0] PREFIX_U16 = 8'hFD;
  localparam logic [7:0] PREFIX_U32 = 8'hFE;
  localparam logic [7:0] PREFIX_U64 = 8'hFF;

  // Value byte counts for each long prefix.
  localparam logic [3:0] LEN_U16 = 4'd2;
  localparam logic [3:0] LEN_U32 = 4'd4;
  localparam logic [3:0] LEN_U64 = 4'd8;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_WIDE  = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  // One input request.
  typedef struct packed {
    logic [7:0]  byte_value;
    logic        script_end;
    logic [31:0] length_limit;
  } csld_in_t;

  // One result request.
  typedef struct packed {
    logic [31:0] decoded_value;
    logic [1:0]  status;
  } csld_out_t;

  // Control and status from the decode core to the top level.
  typedef struct packed {
    logic res_valid;
    logic busy;
  } csld_ctl_t;

endpackage

// File: hdl/csld_ifs.sv
// Valid/ready channel interfaces for the decoder input and result streams.
interface csld_in_if;
  import csld_pkg::*;

  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic        script_end;
  logic [31:0] length_limit;

  modport source (output valid, output byte_value, output script_end,
                  output length_limit, input ready);
  modport sink (input valid, input byte_value, input script_end,
                input length_limit, output ready);
endinterface

interface csld_out_if;
  import csld_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] decoded_value;
  logic [1:0]  status;

  modport source (output valid, output decoded_value, output status, input ready);
  modport sink (input valid, input decoded_value, input status, output ready);
endinterface

// File: hdl/csld_core.sv
// Decode core: holds the decode state and forms the result for each accepted byte.
module csld_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  csld_pkg::csld_in_t  in_req,
  output csld_pkg::csld_out_t res,
  output csld_pkg::csld_ctl_t ctl
);
  import csld_pkg::*;

  logic [3:0]  bytes_left_r, bytes_left_nxt;
  logic [2:0]  byte_position_r, byte_position_nxt;
  logic [31:0] acc_lo_r, acc_lo_nxt;
  logic        acc_hi_r, acc_hi_nxt;
  logic [31:0] held_limit_r, held_limit_nxt;
  logic [31:0] short_value;

  assign short_value = {24'd0, in_req.byte_value};

  // Next state and result for the request at the input.
  always_comb begin
    bytes_left_nxt    = bytes_left_r;
    byte_position_nxt = byte_position_r;
    acc_lo_nxt        = acc_lo_r;
    acc_hi_nxt        = acc_hi_r;
    held_limit_nxt    = held_limit_r;
    ctl.res_valid     = 1'b0;
    ctl.busy          = (bytes_left_r != 4'd0);
    res.decoded_value = 32'd0;
    res.status        = ST_OK;

    if (in_req.script_end) begin
      // End of script: drop any partial value and report truncation.
      bytes_left_nxt    = 4'd0;
      byte_position_nxt = 3'd0;
      acc_lo_nxt        = 32'd0;
      acc_hi_nxt        = 1'b0;
      ctl.res_valid     = 1'b1;
      res.status        = ST_TRUNC;
    end else if (bytes_left_r == 4'd0) begin
      if (in_req.byte_value < PREFIX_U16) begin
        // Short form: the prefix is the value.
        ctl.res_valid     = 1'b1;
        res.decoded_value = short_value;
        res.status        = (short_value <= in_req.length_limit) ? ST_OK : ST_LIMIT;
      end else begin
        // Long form: start gathering value bytes.
        held_limit_nxt    = in_req.length_limit;
        acc_lo_nxt        = 32'd0;
        acc_hi_nxt        = 1'b0;
        byte_position_nxt = 3'd0;
        case (in_req.byte_value)
          PREFIX_U16: bytes_left_nxt = LEN_U16;
          PREFIX_U32: bytes_left_nxt = LEN_U32;
          default:    bytes_left_nxt = LEN_U64;
        endcase
      end
    end else begin
      // Value byte: low four bytes go into the word, upper bytes only flag width.
      for (int i = 0; i < 4; i++) begin
        if (!byte_position_r[2] && (byte_position_r[1:0] == 2'(i))) begin
          acc_lo_nxt[i*8 +: 8] = in_req.byte_value;
        end
      end
      if (byte_position_r[2] && (in_req.byte_value != 8'd0)) begin
        acc_hi_nxt = 1'b1;
      end
      byte_position_nxt = byte_position_r + 3'd1;
      bytes_left_nxt    = bytes_left_r - 4'd1;
      if (bytes_left_r == 4'd1) begin
        // Last byte: finish the value and return to waiting for a prefix.
        ctl.res_valid = 1'b1;
        if (acc_hi_nxt) begin
          res.status = ST_WIDE;
        end else begin
          res.decoded_value = acc_lo_nxt;
          res.status        = (acc_lo_nxt <= held_limit_r) ? ST_OK : ST_LIMIT;
        end
        byte_position_nxt = 3'd0;
        acc_lo_nxt        = 32'd0;
        acc_hi_nxt        = 1'b0;
      end
    end
  end

  // State registers, updated only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r    <= 4'd0;
      byte_position_r <= 3'd0;
      acc_lo_r        <= 32'd0;
      acc_hi_r        <= 1'b0;
      held_limit_r    <= 32'd0;
    end else if (accept) begin
      bytes_left_r    <= bytes_left_nxt;
      byte_position_r <= byte_position_nxt;
      acc_lo_r        <= acc_lo_nxt;
      acc_hi_r        <= acc_hi_nxt;
      held_limit_r    <= held_limit_nxt;
    end
  end

endmodule

// File: hdl/compact_size_length_decoder.sv
// A result appears in the output register in the cycle after its final byte is taken.
// Throughput: one byte per cycle; input ready drops only while a held result is stalled.
// A prefix byte below 0xFD or an end marker gives a result at once; long values after 2/4/8 bytes.
// Reset (synchronous, active low) clears the decode state and empties the output register.
module compact_size_length_decoder (
  input logic         clk,
  input logic         rst_n,
  csld_in_if.sink     in_if,
  csld_out_if.source  out_if
);
  import csld_pkg::*;

  csld_in_t  in_req;
  csld_out_t core_res;
  csld_ctl_t core_ctl;
  csld_out_t out_data_r;
  logic      out_valid_r;
  logic      in_accept;

  // Input handshake: take a byte unless a finished result is stalled.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_accept   = in_if.valid && in_if.ready;
  assign in_req      = '{byte_value: in_if.byte_value, script_end: in_if.script_end,
                         length_limit: in_if.length_limit};

  csld_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .in_req (in_req),
    .res    (core_res),
    .ctl    (core_ctl)
  );

  // Output register holds one result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && core_ctl.res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && core_ctl.res_valid) begin
      out_data_r <= core_res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.decoded_value = out_data_r.decoded_value;
  assign out_if.status        = out_data_r.status;

`ifndef SYNTHESIS
  // A stalled result must block new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.ready |-> !in_if.ready)
    else $error("input accepted while result stalled");

  // An end marker always leaves the decoder waiting for a prefix.
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_if.script_end |=> !core_ctl.busy)
    else $error("decoder busy after end marker");

  // An end marker produces a truncated result on the next cycle.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_if.script_end |=> out_if.valid && out_if.status == ST_TRUNC)
    else $error("end marker gave no truncated result");

  // Truncated and wide results carry a zero value.
  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status == ST_TRUNC || out_if.status == ST_WIDE)
      |-> out_if.decoded_value == 32'd0)
    else $error("nonzero value on error result");
`endif

endmodule
